// ===== hw/rtl/emd_pkg.sv =====
// ----------------------------------------------------------------------------
// emd_pkg: shared types and constants of the echo motion detector
// Register indexes, reset values, item kinds and the records passed between
// the front end, the queue and the execution back end.
// ----------------------------------------------------------------------------
package emd_pkg;

    localparam int SAMPLE_W = 10;
    localparam int BLINK_W  = 16;
    localparam int PING_W   = 8;
    localparam int SQ_W     = 2 * SAMPLE_W;
    localparam int MAG_W    = SQ_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIFF_SHIFT = 4;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_LEVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_OFF_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_OFF_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD     = 3'd4;

    localparam logic [SAMPLE_W-1:0] RST_OFFSET_LEVEL    = 10'd0;
    localparam logic [BLINK_W-1:0]  RST_ON_TICKS        = 16'd40;
    localparam logic [BLINK_W-1:0]  RST_IDLE_OFF_TICKS  = 16'd960;
    localparam logic [BLINK_W-1:0]  RST_ALERT_OFF_TICKS = 16'd160;
    localparam logic [PING_W-1:0]   RST_PING_PERIOD     = 8'd100;

    localparam logic [BLINK_W-1:0] BLINK_MAX = '1;
    localparam logic [PING_W-1:0]  PING_MAX  = '1;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ECHO = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] offset_level;
        logic [BLINK_W-1:0]  on_ticks;
        logic [BLINK_W-1:0]  idle_off_ticks;
        logic [BLINK_W-1:0]  alert_off_ticks;
        logic [PING_W-1:0]   ping_period;
    } t_cfg;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] mag_a;
        logic [SAMPLE_W-1:0] mag_b;
        logic [SAMPLE_W-1:0] sensitivity;
    } t_q_item;

endpackage

// ===== hw/rtl/emd_in_if.sv =====
// ----------------------------------------------------------------------------
// emd_in_if: input item channel
// Valid/ready channel carrying one tick or echo item per transfer.
// ----------------------------------------------------------------------------
interface emd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [emd_pkg::SAMPLE_W-1:0] first_sample;
    logic [emd_pkg::SAMPLE_W-1:0] second_sample;
    logic [emd_pkg::SAMPLE_W-1:0] sensitivity;

    modport source (output valid, func, first_sample, second_sample, sensitivity,
                    input ready);
    modport sink (input valid, func, first_sample, second_sample, sensitivity,
                  output ready);
endinterface

// ===== hw/rtl/emd_out_if.sv =====
// ----------------------------------------------------------------------------
// emd_out_if: result item channel
// Valid/ready channel carrying one result per transfer.
// ----------------------------------------------------------------------------
interface emd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      led;
    logic                      ping_request;
    logic                      motion;
    logic [emd_pkg::MAG_W-1:0] magnitude;

    modport source (output valid, led, ping_request, motion, magnitude, input ready);
    modport sink (input valid, led, ping_request, motion, magnitude, output ready);
endinterface

// ===== hw/rtl/emd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// emd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface emd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [emd_pkg::CFG_IDX_W-1:0]  index;
    logic [emd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/emd_front.sv =====
// ----------------------------------------------------------------------------
// emd_front: input front end
// Holds the configuration registers, accepts items, removes the offset from
// both echo samples and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module emd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    emd_cfg_if.sink            i_cfg,
    emd_in_if.sink             i_item,
    input  logic               i_full,
    output logic               o_push,
    output emd_pkg::t_q_item   o_item,
    output emd_pkg::t_cfg      o_cfg
);

    emd_pkg::t_cfg r_cfg;
    emd_pkg::t_cfg n_cfg;

    function automatic logic [emd_pkg::SAMPLE_W-1:0] abs_offset(
        input logic [emd_pkg::SAMPLE_W-1:0] sample,
        input logic [emd_pkg::SAMPLE_W-1:0] offset
    );
        logic [emd_pkg::SAMPLE_W-1:0] res;
        if (sample >= offset) begin
            res = sample - offset;
        end else begin
            res = offset - sample;
        end
        return res;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                emd_pkg::REG_OFFSET_LEVEL:
                    n_cfg.offset_level = i_cfg.data[emd_pkg::SAMPLE_W-1:0];
                emd_pkg::REG_ON_TICKS:
                    n_cfg.on_ticks = i_cfg.data[emd_pkg::BLINK_W-1:0];
                emd_pkg::REG_IDLE_OFF_TICKS:
                    n_cfg.idle_off_ticks = i_cfg.data[emd_pkg::BLINK_W-1:0];
                emd_pkg::REG_ALERT_OFF_TICKS:
                    n_cfg.alert_off_ticks = i_cfg.data[emd_pkg::BLINK_W-1:0];
                emd_pkg::REG_PING_PERIOD:
                    n_cfg.ping_period = i_cfg.data[emd_pkg::PING_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_level    <= emd_pkg::RST_OFFSET_LEVEL;
            r_cfg.on_ticks        <= emd_pkg::RST_ON_TICKS;
            r_cfg.idle_off_ticks  <= emd_pkg::RST_IDLE_OFF_TICKS;
            r_cfg.alert_off_ticks <= emd_pkg::RST_ALERT_OFF_TICKS;
            r_cfg.ping_period     <= emd_pkg::RST_PING_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_item.func        = i_item.func;
        o_item.mag_a       = abs_offset(i_item.first_sample, r_cfg.offset_level);
        o_item.mag_b       = abs_offset(i_item.second_sample, r_cfg.offset_level);
        o_item.sensitivity = i_item.sensitivity;
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/emd_queue.sv =====
// ----------------------------------------------------------------------------
// emd_queue: item queue between front end and back end
// A small circular buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
module emd_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  emd_pkg::t_q_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output emd_pkg::t_q_item o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    emd_pkg::t_q_item r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != FULL_COUNT)
        else $error("queue pushed while full");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count did not follow a push");
`endif

endmodule

// ===== hw/rtl/emd_back.sv =====
// ----------------------------------------------------------------------------
// emd_back: execution back end
// Squares the corrected samples in one stage, then updates the LED, ping and
// motion state and holds the result until it is transferred.
// ----------------------------------------------------------------------------
module emd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  emd_pkg::t_cfg    i_cfg,
    input  logic             i_q_valid,
    input  emd_pkg::t_q_item i_q_item,
    output logic             o_pop,
    emd_out_if.source        o_result
);

    localparam int SQ_W  = emd_pkg::SQ_W;
    localparam int MAG_W = emd_pkg::MAG_W;
    localparam int SW    = emd_pkg::SAMPLE_W;

    logic                        en;

    logic                        r_s_valid;
    logic                        r_s_func;
    logic [SQ_W-1:0]             r_s_sq_a;
    logic [SQ_W-1:0]             r_s_sq_b;
    logic [SW-1:0]               r_s_sens;

    logic                        r_out_valid;
    logic                        r_led_phase;
    logic                        r_ping;
    logic                        r_motion;
    logic [MAG_W-1:0]            r_last_mag;
    logic [emd_pkg::BLINK_W-1:0] r_blink_count;
    logic [emd_pkg::PING_W-1:0]  r_ping_count;

    logic                        n_out_valid;
    logic                        n_led_phase;
    logic                        n_ping;
    logic                        n_motion;
    logic [MAG_W-1:0]            n_last_mag;
    logic [emd_pkg::BLINK_W-1:0] n_blink_count;
    logic [emd_pkg::PING_W-1:0]  n_ping_count;

    logic [emd_pkg::BLINK_W-1:0] blink_inc;
    logic [emd_pkg::PING_W-1:0]  ping_inc;
    logic [emd_pkg::BLINK_W-1:0] off_limit;
    logic [MAG_W-1:0]            mag;
    logic [MAG_W-1:0]            diff;
    logic                        exec;

    assign en    = !r_out_valid || o_result.ready;
    assign o_pop = en && i_q_valid;
    assign exec  = en && r_s_valid;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_func <= i_q_item.func;
            r_s_sq_a <= {{SW{1'b0}}, i_q_item.mag_a} * {{SW{1'b0}}, i_q_item.mag_a};
            r_s_sq_b <= {{SW{1'b0}}, i_q_item.mag_b} * {{SW{1'b0}}, i_q_item.mag_b};
            r_s_sens <= i_q_item.sensitivity;
        end
    end

    always_comb begin
        blink_inc = (r_blink_count != emd_pkg::BLINK_MAX) ?
                    r_blink_count + emd_pkg::BLINK_W'(1) : r_blink_count;
        ping_inc  = (r_ping_count != emd_pkg::PING_MAX) ?
                    r_ping_count + emd_pkg::PING_W'(1) : r_ping_count;
        off_limit = r_motion ? i_cfg.alert_off_ticks : i_cfg.idle_off_ticks;
        mag       = {1'b0, r_s_sq_a} + {1'b0, r_s_sq_b};
        diff      = (mag > r_last_mag) ? mag - r_last_mag : r_last_mag - mag;

        n_out_valid   = en ? r_s_valid : r_out_valid;
        n_led_phase   = r_led_phase;
        n_ping        = r_ping;
        n_motion      = r_motion;
        n_last_mag    = r_last_mag;
        n_blink_count = r_blink_count;
        n_ping_count  = r_ping_count;

        if (exec) begin
            n_ping = 1'b0;
            if (r_s_func == emd_pkg::FUNC_TICK) begin
                n_blink_count = blink_inc;
                n_ping_count  = ping_inc;
                if (r_led_phase) begin
                    if (blink_inc > i_cfg.on_ticks) begin
                        n_blink_count = '0;
                        n_led_phase   = 1'b0;
                    end
                end else begin
                    if (blink_inc > off_limit) begin
                        n_blink_count = '0;
                        n_led_phase   = 1'b1;
                    end
                end
                if (ping_inc > i_cfg.ping_period) begin
                    n_ping_count = '0;
                    n_ping       = 1'b1;
                end
            end else begin
                n_motion   = diff[MAG_W-1:emd_pkg::DIFF_SHIFT] >
                             {{(MAG_W - emd_pkg::DIFF_SHIFT - SW){1'b0}}, r_s_sens};
                n_last_mag = mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_led_phase   <= 1'b0;
            r_ping        <= 1'b0;
            r_motion      <= 1'b0;
            r_last_mag    <= '0;
            r_blink_count <= '0;
            r_ping_count  <= '0;
        end else begin
            if (en) begin
                r_s_valid <= i_q_valid;
            end
            r_out_valid   <= n_out_valid;
            r_led_phase   <= n_led_phase;
            r_ping        <= n_ping;
            r_motion      <= n_motion;
            r_last_mag    <= n_last_mag;
            r_blink_count <= n_blink_count;
            r_ping_count  <= n_ping_count;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.led          = r_led_phase;
    assign o_result.ping_request = r_ping;
    assign o_result.motion       = r_motion;
    assign o_result.magnitude    = r_last_mag;

`ifndef SYNTH
    a_ping_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ping) |-> r_ping_count == '0)
        else $error("ping request without cleared ping counter");

    a_toggle_clears_blink: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_led_phase != $past(r_led_phase)) |-> r_blink_count == '0)
        else $error("LED toggled without clearing the blink counter");

    a_mag_only_on_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_last_mag != $past(r_last_mag)) |->
        $past(exec && r_s_func == emd_pkg::FUNC_ECHO))
        else $error("magnitude changed without an echo item");
`endif

endmodule

// ===== hw/rtl/echo_motion_detector_heartbeat_core.sv =====
// ----------------------------------------------------------------------------
// echo_motion_detector_heartbeat_core: ultrasonic motion detector with LED
// Top level joining the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
// The block accepts one tick or echo item per clock cycle while the queue is not
// full and returns exactly one result per item, in order. Each item passes
// through the queue and the squaring stage, and the result register then
// holds its result until it is taken. The sustained rate of
// one item per cycle is set by the back end pipeline, which advances whenever
// the result register is empty or being transferred; while results are not
// taken, up to QUEUE_DEPTH items are still accepted into the queue.
// Configuration writes complete in the cycle they are offered and must only be
// made while no item is in flight.
module echo_motion_detector_heartbeat_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    emd_cfg_if.sink i_cfg,
    emd_in_if.sink  i_item,
    emd_out_if.source o_result
);

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    emd_pkg::t_q_item q_in_item;
    emd_pkg::t_q_item q_out_item;
    emd_pkg::t_cfg    cfg;

    emd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (q_in_item),
        .o_cfg   (cfg)
    );

    emd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    emd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_out_item),
        .o_pop     (q_pop),
        .o_result  (o_result)
    );

endmodule

// ===== sim/emd_result_checker.sv =====
// ----------------------------------------------------------------------------
// emd_result_checker: prediction and comparison for the echo motion detector
// Watches the register, item and result channels. Every item transfer is run
// through a local model of the detector, and every result transfer is compared
// field by field with the oldest predicted status. The mismatch count and the
// number of statuses still awaited are handed to the testbench top.
// ----------------------------------------------------------------------------
module emd_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    emd_cfg_if   i_cfg,
    emd_in_if    i_item,
    emd_out_if   i_result,
    output int   o_mismatches,
    output int   o_outstanding
);
    import emd_pkg::*;

    typedef struct {
        logic             led;
        logic             ping_request;
        logic             motion;
        logic [MAG_W-1:0] magnitude;
    } t_status;

    t_cfg               regs;
    logic               led_on;
    logic [BLINK_W-1:0] blink_count;
    logic [PING_W-1:0]  ping_count;
    logic [MAG_W-1:0]   last_mag;
    logic               motion_seen;
    t_status            status_due[$];
    int                 mismatch_count = 0;
    int                 awaited = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = awaited;

    function automatic logic [SQ_W-1:0] offset_square(input logic [SAMPLE_W-1:0] sample);
        int delta;
        delta = int'(sample) - int'(regs.offset_level);
        if (delta < 0) begin
            delta = -delta;
        end
        return SQ_W'(delta * delta);
    endfunction

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_OFFSET_LEVEL:    regs.offset_level    = value[SAMPLE_W-1:0];
            REG_ON_TICKS:        regs.on_ticks        = value[BLINK_W-1:0];
            REG_IDLE_OFF_TICKS:  regs.idle_off_ticks  = value[BLINK_W-1:0];
            REG_ALERT_OFF_TICKS: regs.alert_off_ticks = value[BLINK_W-1:0];
            REG_PING_PERIOD:     regs.ping_period     = value[PING_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_detector(input logic func,
                                    input logic [SAMPLE_W-1:0] first,
                                    input logic [SAMPLE_W-1:0] second,
                                    input logic [SAMPLE_W-1:0] sens,
                                    output t_status status);
        logic [BLINK_W-1:0] off_limit;
        logic [MAG_W-1:0]   mag;
        logic [MAG_W-1:0]   diff;
        logic               ping;
        ping = 1'b0;
        if (func == FUNC_TICK) begin
            if (blink_count != BLINK_MAX) begin
                blink_count = blink_count + 1'b1;
            end
            if (ping_count != PING_MAX) begin
                ping_count = ping_count + 1'b1;
            end
            if (led_on) begin
                if (blink_count > regs.on_ticks) begin
                    blink_count = '0;
                    led_on = 1'b0;
                end
            end else begin
                off_limit = motion_seen ? regs.alert_off_ticks : regs.idle_off_ticks;
                if (blink_count > off_limit) begin
                    blink_count = '0;
                    led_on = 1'b1;
                end
            end
            if (ping_count > regs.ping_period) begin
                ping_count = '0;
                ping = 1'b1;
            end
        end else begin
            mag = MAG_W'(offset_square(first)) + MAG_W'(offset_square(second));
            diff = (mag > last_mag) ? mag - last_mag : last_mag - mag;
            motion_seen = (diff >> DIFF_SHIFT) > MAG_W'(sens);
            last_mag = mag;
        end
        status.led          = led_on;
        status.ping_request = ping;
        status.motion       = motion_seen;
        status.magnitude    = last_mag;
    endtask

    task automatic compare_field(input string field, input logic [MAG_W-1:0] expected,
                                 input logic [MAG_W-1:0] actual);
        if (actual !== expected) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        t_status fresh;
        t_status oldest;
        if (!i_rst_n) begin
            regs.offset_level    = RST_OFFSET_LEVEL;
            regs.on_ticks        = RST_ON_TICKS;
            regs.idle_off_ticks  = RST_IDLE_OFF_TICKS;
            regs.alert_off_ticks = RST_ALERT_OFF_TICKS;
            regs.ping_period     = RST_PING_PERIOD;
            led_on      = 1'b0;
            blink_count = '0;
            ping_count  = '0;
            last_mag    = '0;
            motion_seen = 1'b0;
            status_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                apply_register(i_cfg.index, i_cfg.data);
            end
            if (i_result.valid && i_result.ready) begin
                if (status_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result transfer expected none, actual magnitude %0d",
                             $time, i_result.magnitude);
                end else begin
                    oldest = status_due.pop_front();
                    compare_field("led", oldest.led, i_result.led);
                    compare_field("ping_request", oldest.ping_request, i_result.ping_request);
                    compare_field("motion", oldest.motion, i_result.motion);
                    compare_field("magnitude", oldest.magnitude, i_result.magnitude);
                end
            end
            if (i_item.valid && i_item.ready) begin
                advance_detector(i_item.func, i_item.first_sample, i_item.second_sample,
                                 i_item.sensitivity, fresh);
                status_due.push_back(fresh);
            end
        end
        awaited = status_due.size();
    end

endmodule

// ===== sim/echo_motion_detector_heartbeat_core_tb.sv =====
// ----------------------------------------------------------------------------
// echo_motion_detector_heartbeat_core_tb: testbench top of the motion detector
// Drives directed and random tick and echo items through the core under three
// flow-control regimes, reprogramming the registers between phases, and ends
// with a run of ticks that saturates the ping counter. The checker beside
// the core predicts every result; this top only makes stimulus and reports.
// ----------------------------------------------------------------------------
module echo_motion_detector_heartbeat_core_tb;
    import emd_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 10;
    localparam int SEGMENT_ITEMS = 78;
    localparam int HOLD_ITEMS    = 270;
    localparam int ECHO_PCT      = 30;
    localparam int SENDER_IDLE[3]    = '{17, 71, 0};
    localparam int RECEIVER_STALL[3] = '{71, 17, 0};

    logic                i_clk;
    logic                i_rst_n;
    int                  sender_idle_pct;
    int                  receiver_stall_pct;
    int                  mismatches;
    int                  outstanding;
    int unsigned         quiet_cycles = 0;
    logic [SAMPLE_W-1:0] prev_first;
    logic [SAMPLE_W-1:0] prev_second;
    logic [SAMPLE_W-1:0] offset_now;

    emd_cfg_if cfg_ch();
    emd_in_if  item_ch();
    emd_out_if result_ch();

    echo_motion_detector_heartbeat_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    emd_result_checker result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg_ch),
        .i_item        (item_ch),
        .i_result      (result_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(negedge i_clk) begin
        result_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready)
                || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic settle();
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic program_registers(input logic [SAMPLE_W-1:0] offset,
                                     input logic [BLINK_W-1:0] on_t,
                                     input logic [BLINK_W-1:0] idle_t,
                                     input logic [BLINK_W-1:0] alert_t,
                                     input logic [PING_W-1:0] period);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        settle();
        for (int idx = REG_PING_PERIOD + 1; idx < 2 ** CFG_IDX_W; idx++) begin
            write_register(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        end
        write_register(REG_OFFSET_LEVEL, {junk[CFG_DATA_W-1:SAMPLE_W], offset});
        write_register(REG_ON_TICKS, on_t);
        write_register(REG_IDLE_OFF_TICKS, idle_t);
        write_register(REG_ALERT_OFF_TICKS, alert_t);
        write_register(REG_PING_PERIOD, {junk[CFG_DATA_W-1:PING_W], period});
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        offset_now = offset;
    endtask

    task automatic random_registers();
        logic [PING_W-1:0] period;
        if ($urandom_range(3) == 0) begin
            period = PING_W'($urandom_range(200, 255));
        end else begin
            period = PING_W'($urandom_range(0, 40));
        end
        program_registers(SAMPLE_W'($urandom), BLINK_W'($urandom_range(0, 30)),
                          BLINK_W'($urandom_range(0, 60)), BLINK_W'($urandom_range(0, 20)),
                          period);
    endtask

    task automatic send_item(input logic func, input logic [SAMPLE_W-1:0] first,
                             input logic [SAMPLE_W-1:0] second,
                             input logic [SAMPLE_W-1:0] sens);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            item_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid         = 1'b1;
        item_ch.func          = func;
        item_ch.first_sample  = first;
        item_ch.second_sample = second;
        item_ch.sensitivity   = sens;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    // Echo items either repeat the last pair with slight jitter, sit close to
    // the offset, or are fully random, so the motion flag goes both ways.
    task automatic send_random_item(input int echo_pct);
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
        logic [SAMPLE_W-1:0] sens;
        first  = SAMPLE_W'($urandom);
        second = SAMPLE_W'($urandom);
        sens   = SAMPLE_W'($urandom);
        if ($urandom_range(99) >= echo_pct) begin
            send_item(FUNC_TICK, first, second, sens);
        end else begin
            case ($urandom_range(2))
                0: begin
                    first  = prev_first ^ SAMPLE_W'($urandom_range(0, 3));
                    second = prev_second ^ SAMPLE_W'($urandom_range(0, 3));
                    sens   = SAMPLE_W'($urandom_range(0, 63));
                end
                1: begin
                    first  = offset_now + SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
                    second = offset_now + SAMPLE_W'($urandom_range(0, 63)) - SAMPLE_W'(32);
                    sens   = SAMPLE_W'($urandom_range(0, 255));
                end
                default: ;
            endcase
            prev_first  = first;
            prev_second = second;
            send_item(FUNC_ECHO, first, second, sens);
        end
    endtask

    task automatic run_segment(input int count, input int echo_pct);
        repeat (count) send_random_item(echo_pct);
    endtask

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        item_ch.valid         = 1'b0;
        item_ch.func          = FUNC_TICK;
        item_ch.first_sample  = '0;
        item_ch.second_sample = '0;
        item_ch.sensitivity   = '0;
        result_ch.ready       = 1'b0;
        prev_first  = '0;
        prev_second = '0;
        offset_now  = RST_OFFSET_LEVEL;
        sender_idle_pct    = SENDER_IDLE[0];
        receiver_stall_pct = RECEIVER_STALL[0];
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: sample extremes and the sensitivity boundary.
        send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_ECHO, '0, '0, '0);
        send_item(FUNC_ECHO, '1, '1, '0);
        send_item(FUNC_ECHO, '1, '1, '1);
        send_item(FUNC_ECHO, '0, '0, '1);
        send_item(FUNC_ECHO, 10'd4, 10'd4, 10'd1);
        send_item(FUNC_ECHO, 10'd4, 10'd0, 10'd0);
        send_item(FUNC_TICK, '1, '1, '1);

        // Zero limits toggle the LED and request a ping on every tick.
        program_registers('1, '0, '0, '0, '0);
        send_item(FUNC_ECHO, '0, '1, '0);
        send_item(FUNC_ECHO, '0, '0, '0);
        repeat (4) send_item(FUNC_TICK, '0, '0, '0);
        send_item(FUNC_ECHO, 10'd512, '1, 10'd5);
        send_item(FUNC_TICK, '1, '0, '1);

        program_registers(10'd512, '1, '1, '1, '1);
        repeat (3) send_item(FUNC_TICK, '0, '1, '0);
        send_item(FUNC_ECHO, '0, '1, '1);
        send_item(FUNC_ECHO, '1, '0, '1);

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct    = SENDER_IDLE[phase];
            receiver_stall_pct = RECEIVER_STALL[phase];
            repeat (3) begin
                random_registers();
                run_segment(SEGMENT_ITEMS, ECHO_PCT);
            end
        end

        // Maximum limits let the ping counter saturate; lowering the limits
        // afterwards must toggle the LED and request a ping on the next tick.
        program_registers(SAMPLE_W'($urandom), '1, '1, '1, '1);
        run_segment(HOLD_ITEMS, 1);
        program_registers(offset_now, 16'd3, 16'd5, 16'd2, 8'd10);
        run_segment(60, ECHO_PCT);

        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
